// File: design/upd_pkg.sv
package upd_pkg;

   localparam int unsigned LEN_W = 13;
   localparam int unsigned LEN_FIELD_MAX = 8191;
   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOW_A   = 8'h61;
   localparam logic [7:0] CHAR_LOW_F   = 8'h66;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_F    = 8'h46;
   localparam logic [3:0] LETTER_BIAS  = 4'd9;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   typedef logic [1:0] res_count_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= CHAR_ZERO && c <= CHAR_NINE) ||
               (c >= CHAR_LOW_A && c <= CHAR_LOW_F) ||
               (c >= CHAR_UP_A && c <= CHAR_UP_F);
   endfunction

   // Letters map through their low three bits: 'a'/'A' have 1 there, plus 9 gives 10.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] diff;
      diff = c - CHAR_ZERO;
      if (c <= CHAR_NINE) begin
         hex_value = diff[3:0];
      end else begin
         hex_value = {1'b0, c[2:0]} + LETTER_BIAS;
      end
   endfunction

endpackage

// File: design/url_percent_decoder.sv
// URL percent decoder: takes one string character per transaction (req_last on the final
// one) and returns the decoded bytes, "%XY" as one byte and '+' as a space. Each character
// is decoded in the cycle it is accepted and its zero to three results are loaded into a
// small result register; one result leaves per cycle while rsp_stall is low. Ordinary
// characters flow at one per cycle with no bubbles while rsp_stall is low; a character that
// yields two or three results (a broken escape or a flushed escape at string end) holds
// req_stall high while the result register drains. An escape that decodes to zero gives
// one result with rsp_bad_string set and the rest of that string is consumed without results.
// rsp_decoded_length is valid on the result with rsp_string_end and saturates at the
// smaller of MAX_LENGTH and 8191.
module url_percent_decoder #(
   parameter int unsigned MAX_LENGTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_run_last,
   output logic                     rsp_string_end,
   output logic                     rsp_bad_string,
   output logic [upd_pkg::LEN_W-1:0] rsp_decoded_length
);

   localparam int unsigned CAP_INT = (MAX_LENGTH > upd_pkg::LEN_FIELD_MAX) ?
                                     upd_pkg::LEN_FIELD_MAX : MAX_LENGTH;
   localparam logic [upd_pkg::LEN_W-1:0] LEN_CAP = upd_pkg::LEN_W'(CAP_INT);

   // Decoder state.
   upd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         held_ff, held_in;
   logic               dropping_ff, dropping_in;
   logic [upd_pkg::LEN_W-1:0] count_ff, count_in;

   // Result register.
   logic                   busy_ff, busy_in;
   logic [7:0]             byte_ff [upd_pkg::MAX_RESULTS];
   upd_pkg::res_count_type n_ff, rd_ff;
   logic                   end_ff, bad_ff;
   logic [upd_pkg::LEN_W-1:0] len_ff;

   logic                   accept, pop, final_entry;
   logic                   in_hex, err, plain;
   logic [7:0]             decoded;
   logic [7:0]             res_byte [upd_pkg::MAX_RESULTS];
   upd_pkg::res_count_type n_res;
   logic [upd_pkg::LEN_W:0] count_sum;
   logic [upd_pkg::LEN_W-1:0] count_sat;

   assign final_entry = (rd_ff == n_ff - 2'd1);
   assign pop         = busy_ff && !rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign req_stall   = busy_ff && !(pop && final_entry);

   assign in_hex  = upd_pkg::is_hex(req_data_byte);
   assign decoded = {upd_pkg::hex_value(held_ff), upd_pkg::hex_value(req_data_byte)};

   // Results of the incoming character.
   always_comb begin
      n_res = '0;
      err   = 1'b0;
      plain = 1'b0;
      for (int i = 0; i < upd_pkg::MAX_RESULTS; i++) begin
         res_byte[i] = '0;
      end
      if (!dropping_ff) begin
         unique case (phase_ff)
            upd_pkg::PH_PCT: begin
               if (in_hex) begin
                  if (req_last) begin
                     res_byte[0] = upd_pkg::CHAR_PERCENT;
                     res_byte[1] = req_data_byte;
                     n_res       = 2'd2;
                  end
               end else begin
                  res_byte[0] = upd_pkg::CHAR_PERCENT;
                  n_res       = 2'd1;
                  plain       = 1'b1;
               end
            end
            upd_pkg::PH_DIGIT: begin
               if (in_hex) begin
                  if (decoded == 8'd0) begin
                     err = 1'b1;
                  end else begin
                     res_byte[0] = decoded;
                     n_res       = 2'd1;
                  end
               end else begin
                  res_byte[0] = upd_pkg::CHAR_PERCENT;
                  res_byte[1] = held_ff;
                  n_res       = 2'd2;
                  plain       = 1'b1;
               end
            end
            default: begin
               plain = 1'b1;
            end
         endcase
         if (plain) begin
            if (req_data_byte == upd_pkg::CHAR_PERCENT) begin
               if (req_last) begin
                  res_byte[n_res] = upd_pkg::CHAR_PERCENT;
                  n_res           = n_res + 2'd1;
               end
            end else if (req_data_byte == upd_pkg::CHAR_PLUS) begin
               res_byte[n_res] = upd_pkg::CHAR_SPACE;
               n_res           = n_res + 2'd1;
            end else begin
               res_byte[n_res] = req_data_byte;
               n_res           = n_res + 2'd1;
            end
         end
      end
   end

   // The count only grows up to the cap, so adding all results at once and clamping matches.
   assign count_sum = {1'b0, count_ff} + {{(upd_pkg::LEN_W - 1){1'b0}}, n_res};
   assign count_sat = (count_sum > {1'b0, LEN_CAP}) ? LEN_CAP : count_sum[upd_pkg::LEN_W-1:0];

   // Next decoder state.
   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      dropping_in = dropping_ff;
      count_in    = count_ff;
      if (accept) begin
         if (dropping_ff) begin
            if (req_last) begin
               dropping_in = 1'b0;
            end
         end else begin
            phase_in = upd_pkg::PH_IDLE;
            if (phase_ff == upd_pkg::PH_PCT && in_hex && !req_last) begin
               held_in  = req_data_byte;
               phase_in = upd_pkg::PH_DIGIT;
            end
            if (plain && req_data_byte == upd_pkg::CHAR_PERCENT && !req_last) begin
               phase_in = upd_pkg::PH_PCT;
            end
            if (err) begin
               dropping_in = !req_last;
               phase_in    = upd_pkg::PH_IDLE;
               held_in     = '0;
               count_in    = '0;
            end else if (req_last) begin
               held_in  = '0;
               count_in = '0;
            end else begin
               count_in = count_sat;
            end
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (pop && final_entry) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = err || (n_res != 2'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= upd_pkg::PH_IDLE;
         held_ff     <= '0;
         dropping_ff <= 1'b0;
         count_ff    <= '0;
         busy_ff     <= 1'b0;
         rd_ff       <= '0;
         n_ff        <= '0;
      end else begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         dropping_ff <= dropping_in;
         count_ff    <= count_in;
         busy_ff     <= busy_in;
         if (accept) begin
            rd_ff <= '0;
            n_ff  <= err ? 2'd1 : n_res;
         end else if (pop && !final_entry) begin
            rd_ff <= rd_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < upd_pkg::MAX_RESULTS; i++) begin
            byte_ff[i] <= res_byte[i];
         end
         end_ff <= req_last || err;
         bad_ff <= err;
         len_ff <= err ? '0 : count_sat;
      end
   end

   assign rsp_valid          = busy_ff;
   assign rsp_out_byte       = byte_ff[rd_ff];
   assign rsp_run_last       = final_entry;
   assign rsp_string_end     = final_entry && end_ff;
   assign rsp_bad_string     = bad_ff;
   assign rsp_decoded_length = (final_entry && end_ff) ? len_ff : '0;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_string |->
         rsp_string_end && rsp_run_last && rsp_out_byte == 8'd0 && rsp_decoded_length == '0)
      else $error("error result is malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last)
      else $error("string end on a result that is not the last of its character");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_decoded_length <= LEN_CAP)
      else $error("decoded length exceeds its cap");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("results of one character were cut short");

endmodule

// File: dv/url_percent_decoder_test.sv
module url_percent_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_LEN = 4096;
   localparam int unsigned LEN_CAP = (MAX_LEN > upd_pkg::LEN_FIELD_MAX) ?
                                     upd_pkg::LEN_FIELD_MAX : MAX_LEN;
   localparam logic [7:0] CASE_BIT = 8'h20;
   localparam int RANDOM_ITEMS = 74;
   localparam int LONG_HOLD = 80;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0]                out_byte;
      logic                      run_last;
      logic                      string_end;
      logic                      bad_string;
      logic [upd_pkg::LEN_W-1:0] length;
   } decoded_char_type;

   typedef struct {
      logic [7:0]       data;
      logic             last;
      bit               typed;
      int               n_typed;
      decoded_char_type res;
   } url_char_type;

   localparam decoded_char_type NO_RESULT = '0;
   localparam decoded_char_type REJECTED = '{8'h00, 1'b1, 1'b1, 1'b1, '0};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_data_byte = 8'h00;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_run_last;
   logic                 rsp_string_end;
   logic                 rsp_bad_string;
   logic [upd_pkg::LEN_W-1:0] rsp_decoded_length;

   // Decoder state as the block should hold it.
   upd_pkg::phase_type   esc_phase = upd_pkg::PH_IDLE;
   logic [7:0]           held_char = 8'h00;
   bit                   skipping = 1'b0;
   logic [upd_pkg::LEN_W-1:0] char_count = '0;

   url_char_type         stimulus[$];
   decoded_char_type     expected_chars[$];
   int                   taken = 0;
   int                   mismatches = 0;
   bit                   hold_request = 1'b0;

   // Rows with a typed result are checked against that value; the rest use the predictor.
   url_char_type directed_rows[26] = '{
      '{"A",                   1'b0, 1'b1, 1, '{"A",                 1'b1, 1'b0, 1'b0, '0}},
      '{upd_pkg::CHAR_PLUS,    1'b0, 1'b1, 1, '{upd_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0, '0}},
      '{8'hFF,                 1'b0, 1'b1, 1, '{8'hFF,               1'b1, 1'b0, 1'b0, '0}},
      '{8'h00,                 1'b0, 1'b1, 1, '{8'h00,               1'b1, 1'b0, 1'b0, '0}},
      '{8'h01,                 1'b1, 1'b1, 1, '{8'h01,               1'b1, 1'b1, 1'b0, 13'd5}},
      '{upd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 0, NO_RESULT},
      '{upd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 0, NO_RESULT},
      '{"4",                   1'b0, 1'b0, 0, NO_RESULT},
      '{"1",                   1'b0, 1'b0, 0, NO_RESULT},
      '{upd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 0, NO_RESULT},
      '{"a",                   1'b0, 1'b0, 0, NO_RESULT},
      '{"g",                   1'b0, 1'b0, 0, NO_RESULT},
      '{upd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 0, NO_RESULT},
      '{"F",                   1'b0, 1'b0, 0, NO_RESULT},
      '{"f",                   1'b1, 1'b0, 0, NO_RESULT},
      '{upd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 0, NO_RESULT},
      '{"0",                   1'b0, 1'b0, 0, NO_RESULT},
      '{"0",                   1'b0, 1'b1, 1, REJECTED},
      '{"x",                   1'b1, 1'b1, 0, NO_RESULT},
      '{upd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 0, NO_RESULT},
      '{"0",                   1'b0, 1'b0, 0, NO_RESULT},
      '{"0",                   1'b1, 1'b1, 1, REJECTED},
      '{upd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 0, NO_RESULT},
      '{"B",                   1'b0, 1'b0, 0, NO_RESULT},
      '{"z",                   1'b1, 1'b0, 0, NO_RESULT},
      '{upd_pkg::CHAR_PERCENT, 1'b1, 1'b1, 1,
        '{upd_pkg::CHAR_PERCENT, 1'b1, 1'b1, 1'b0, 13'd1}}
   };

   url_percent_decoder #(
      .MAX_LENGTH(MAX_LEN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .rsp_string_end(rsp_string_end),
      .rsp_bad_string(rsp_bad_string),
      .rsp_decoded_length(rsp_decoded_length)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit is_hex_digit(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | CASE_BIT;
      return (c >= upd_pkg::CHAR_ZERO && c <= upd_pkg::CHAR_NINE) ||
             (folded >= upd_pkg::CHAR_LOW_A && folded <= upd_pkg::CHAR_LOW_F);
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      if (c <= upd_pkg::CHAR_NINE) begin
         v = c - upd_pkg::CHAR_ZERO;
      end else begin
         v = (c | CASE_BIT) - upd_pkg::CHAR_LOW_A + 8'd10;
      end
      return v[3:0];
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] random_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return upd_pkg::CHAR_ZERO + 8'(v);
      end
      return ($urandom_range(0, 1) ? upd_pkg::CHAR_UP_A : upd_pkg::CHAR_LOW_A) + 8'(v - 10);
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(8'h21, 8'h7E));
      return (c == upd_pkg::CHAR_PERCENT) ? "~" : c;
   endfunction

   function automatic logic [7:0] non_hex_char();
      case ($urandom_range(0, 4))
         0: return 8'($urandom_range("g", "z"));
         1: return 8'($urandom_range("G", "Z"));
         2: return upd_pkg::CHAR_PERCENT;
         3: return upd_pkg::CHAR_PLUS;
         default: return 8'($urandom_range(8'h80, 8'hFF));
      endcase
   endfunction

   // Works out what one accepted character produces and queues it.
   task automatic decode_url_char(input logic [7:0] c, input logic fin);
      logic [7:0] outs[$];
      logic [7:0] v;
      bit literal;
      bit reject;
      decoded_char_type r;
      literal = 1'b0;
      reject = 1'b0;
      if (skipping) begin
         if (fin) skipping = 1'b0;
         return;
      end
      case (esc_phase)
         upd_pkg::PH_PCT: begin
            esc_phase = upd_pkg::PH_IDLE;
            if (is_hex_digit(c)) begin
               if (!fin) begin
                  held_char = c;
                  esc_phase = upd_pkg::PH_DIGIT;
                  return;
               end
               outs.push_back(upd_pkg::CHAR_PERCENT);
               outs.push_back(c);
            end else begin
               outs.push_back(upd_pkg::CHAR_PERCENT);
               literal = 1'b1;
            end
         end
         upd_pkg::PH_DIGIT: begin
            esc_phase = upd_pkg::PH_IDLE;
            if (is_hex_digit(c)) begin
               v = {digit_value(held_char), digit_value(c)};
               if (v == 8'h00) begin
                  reject = 1'b1;
               end else begin
                  outs.push_back(v);
               end
            end else begin
               outs.push_back(upd_pkg::CHAR_PERCENT);
               outs.push_back(held_char);
               literal = 1'b1;
            end
         end
         default: begin
            esc_phase = upd_pkg::PH_IDLE;
            literal = 1'b1;
         end
      endcase
      if (literal) begin
         if (c == upd_pkg::CHAR_PERCENT) begin
            if (fin) begin
               outs.push_back(upd_pkg::CHAR_PERCENT);
            end else begin
               esc_phase = upd_pkg::PH_PCT;
            end
         end else if (c == upd_pkg::CHAR_PLUS) begin
            outs.push_back(upd_pkg::CHAR_SPACE);
         end else begin
            outs.push_back(c);
         end
      end
      if (reject) begin
         expected_chars.push_back(REJECTED);
         skipping = !fin;
         esc_phase = upd_pkg::PH_IDLE;
         held_char = 8'h00;
         char_count = '0;
         return;
      end
      foreach (outs[k]) begin
         if (char_count < LEN_CAP) char_count++;
         r.out_byte = outs[k];
         r.run_last = (k == outs.size() - 1);
         r.string_end = r.run_last && fin;
         r.bad_string = 1'b0;
         r.length = r.string_end ? char_count : '0;
         expected_chars.push_back(r);
      end
      if (fin) begin
         esc_phase = upd_pkg::PH_IDLE;
         held_char = 8'h00;
         char_count = '0;
      end
   endtask

   // Mostly well-formed URL text; the string may stop in the middle of an escape.
   task automatic append_random_string(input int n_chars);
      logic [7:0] chars[$];
      logic [7:0] d1;
      logic [7:0] d2;
      int r;
      url_char_type row;
      while (chars.size() < n_chars) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            chars.push_back(plain_char());
         end else if (r < 50) begin
            chars.push_back(upd_pkg::CHAR_PLUS);
         end else if (r < 75) begin
            d1 = random_hex_char();
            d2 = random_hex_char();
            if (d1 == upd_pkg::CHAR_ZERO && d2 == upd_pkg::CHAR_ZERO) d2 = "a";
            chars.push_back(upd_pkg::CHAR_PERCENT);
            chars.push_back(d1);
            chars.push_back(d2);
         end else if (r < 85) begin
            chars.push_back(upd_pkg::CHAR_PERCENT);
            if ($urandom_range(0, 1)) chars.push_back(random_hex_char());
            chars.push_back(non_hex_char());
         end else if (r < 89) begin
            chars.push_back(upd_pkg::CHAR_PERCENT);
            chars.push_back(upd_pkg::CHAR_ZERO);
            chars.push_back(upd_pkg::CHAR_ZERO);
         end else begin
            chars.push_back(8'($urandom_range(1, 255)));
         end
      end
      for (int k = 0; k < n_chars; k++) begin
         row = '{chars[k], (k == n_chars - 1), 1'b0, 0, NO_RESULT};
         stimulus.push_back(row);
      end
   endtask

   initial begin
      int gap;
      int random_start;
      foreach (directed_rows[i]) stimulus.push_back(directed_rows[i]);
      random_start = stimulus.size();
      while (stimulus.size() - random_start < RANDOM_ITEMS) begin
         append_random_string($urandom_range(1, 10));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < stimulus.size(); i++) begin
         if (i == random_start) hold_request = 1'b1;
         gap = idle_length();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= stimulus[i].data;
         req_last <= stimulus[i].last;
         do @(posedge clock); while (req_stall);
      end
      req_valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("url_percent_decoder test passed");
      end else begin
         $display("url_percent_decoder test failed");
      end
      $finish;
   end

   // Receiver back-pressure; one long hold-off lets the block fill and stall its input.
   initial begin
      int run;
      int hold;
      wait (!reset);
      forever begin
         run = $urandom_range(1, 20);
         repeat (run) @(posedge clock);
         hold = idle_length();
         if (hold_request) begin
            hold = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      decoded_char_type want;
      int prior_size;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            prior_size = expected_chars.size();
            decode_url_char(req_data_byte, req_last);
            if (stimulus[taken].typed) begin
               while (expected_chars.size() > prior_size) void'(expected_chars.pop_back());
               if (stimulus[taken].n_typed > 0) expected_chars.push_back(stimulus[taken].res);
            end
            taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: result byte %02h arrived with no transaction expected",
                        $realtime, rsp_out_byte);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h, got %02h",
                           $realtime, want.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $display("%0t: run_last expected %0b, got %0b",
                           $realtime, want.run_last, rsp_run_last);
                  mismatches++;
               end
               if (rsp_string_end !== want.string_end) begin
                  $display("%0t: string_end expected %0b, got %0b",
                           $realtime, want.string_end, rsp_string_end);
                  mismatches++;
               end
               if (rsp_bad_string !== want.bad_string) begin
                  $display("%0t: bad_string expected %0b, got %0b",
                           $realtime, want.bad_string, rsp_bad_string);
                  mismatches++;
               end
               if (rsp_decoded_length !== want.length) begin
                  $display("%0t: decoded_length expected %0d, got %0d",
                           $realtime, want.length, rsp_decoded_length);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("url_percent_decoder test failed");
      $finish;
   end

endmodule
